### rtl/core/sbfd_pkg.sv
// Shared types and constants for the SBUS frame deframer and decoder.
`timescale 1ns / 1ps

package sbfd_pkg;

  localparam logic [7:0] StartMark  = 8'h0F;
  localparam logic [7:0] EndMark    = 8'h00;
  localparam int         StoreDepth = 23;
  localparam int         DataBytes  = 22;
  localparam int         ChanCount  = 16;
  localparam int         ChanBits   = 11;
  localparam int         FlagBits   = 4;
  localparam int         DataWidth  = DataBytes * 8;

  // Last frame position that is still stored; the byte after it closes the frame.
  localparam logic [4:0] LastDataPos = 5'(StoreDepth);
  localparam logic [3:0] LastChan    = 4'(ChanCount - 1);

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        digital_ch17;
    logic        digital_ch18;
    logic        lost_frame;
    logic        failsafe_active;
    logic        last_of_frame;
  } result_t;

  // Completed frame handed from the deframer to the unpacker.
  typedef struct packed {
    logic                 load;
    logic [DataWidth-1:0] chan_bits;
    logic [FlagBits-1:0]  flags;
  } frame_t;

endpackage

### rtl/core/sbfd_stream_if.sv
// Valid/ready stream interface with a typed payload.
`timescale 1ns / 1ps

interface sbfd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/sbfd_deframer.sv
// Start-byte hunt, frame byte collection and end-byte check.
`timescale 1ns / 1ps

module sbfd_deframer (
  input  logic                 clk,
  input  logic                 rst,
  sbfd_stream_if.sink          rx,
  input  logic                 unpack_busy,
  output sbfd_pkg::frame_t     frame
);

  logic       in_frame;
  logic [4:0] byte_position;
  logic [7:0] frame_store [sbfd_pkg::StoreDepth];

  logic store_pos;
  logic final_byte;
  logic accept;

  assign store_pos  = (byte_position >= 5'd1) && (byte_position <= sbfd_pkg::LastDataPos);
  assign final_byte = in_frame && !store_pos;
  // Stall only the closing byte while the previous frame is still unpacking.
  assign rx.ready   = !(final_byte && unpack_busy);
  assign accept     = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_position <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        if (rx.data.rx_byte == sbfd_pkg::StartMark) begin
          in_frame      <= 1'b1;
          byte_position <= 5'd1;
        end
      end else if (store_pos) begin
        byte_position <= byte_position + 5'd1;
      end else begin
        in_frame      <= 1'b0;
        byte_position <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame && store_pos) begin
      frame_store[byte_position - 5'd1] <= rx.data.rx_byte;
    end
  end

  always_comb begin
    frame.load  = accept && final_byte && (rx.data.rx_byte == sbfd_pkg::EndMark);
    frame.flags = frame_store[sbfd_pkg::StoreDepth-1][sbfd_pkg::FlagBits-1:0];
    for (int k = 0; k < sbfd_pkg::DataBytes; k++) begin
      frame.chan_bits[8*k +: 8] = frame_store[k];
    end
  end

endmodule

### rtl/core/sbfd_unpacker.sv
// Frame snapshot, channel sequencer and result register.
`timescale 1ns / 1ps

module sbfd_unpacker (
  input  logic                 clk,
  input  logic                 rst,
  input  sbfd_pkg::frame_t     frame,
  output logic                 busy,
  sbfd_stream_if.source        res
);

  logic [sbfd_pkg::DataWidth-1:0] snap_bits;
  logic [sbfd_pkg::FlagBits-1:0]  snap_flags;
  logic [3:0]                     chan;
  logic                           out_valid;
  sbfd_pkg::result_t              out_data;

  logic [7:0]  bit_off;
  logic [10:0] chan_value;
  logic        advance;

  assign bit_off    = 8'(chan) * 8'(sbfd_pkg::ChanBits);
  assign chan_value = snap_bits[bit_off +: sbfd_pkg::ChanBits];
  assign advance    = busy && (!out_valid || res.ready);

  assign res.valid = out_valid;
  assign res.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      chan      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (frame.load) begin
        busy <= 1'b1;
        chan <= '0;
      end else if (advance) begin
        chan <= chan + 4'd1;
        if (chan == sbfd_pkg::LastChan) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.load) begin
      snap_bits  <= frame.chan_bits;
      snap_flags <= frame.flags;
    end
    if (advance) begin
      out_data.channel_index   <= chan;
      out_data.channel_value   <= chan_value;
      out_data.digital_ch17    <= snap_flags[0];
      out_data.digital_ch18    <= snap_flags[1];
      out_data.lost_frame      <= snap_flags[2];
      out_data.failsafe_active <= snap_flags[3];
      out_data.last_of_frame   <= (chan == sbfd_pkg::LastChan);
    end
  end

endmodule

### rtl/core/sbus_frame_deframer_decoder_core.sv
// Top level of the SBUS frame deframer and decoder.
`timescale 1ns / 1ps
//
//  Port   Direction  Payload                          Meaning
//  rx     sink       rx_byte (8b)                     received serial bytes
//  chan   source     channel_index, channel_value,    one decoded channel per
//                    four flag bits, last_of_frame     transfer, 16 per frame
//
//  One byte per cycle is taken on rx, unless a closing byte waits on a busy
//  unpacker. Data and flag bytes are stored in the cycle of their transfer;
//  a good end byte copies the frame into the unpacker, which then sends one
//  channel per cycle while chan is not stalled, 16 transfers; the first is
//  valid once the snapshot and then the result register have loaded. rst
//  (synchronous) drops any partial frame and any pending results. A stalled
//  chan only holds rx back on the next closing byte while channels remain.
//
module sbus_frame_deframer_decoder_core (
  input  logic           clk,
  input  logic           rst,
  sbfd_stream_if.sink    rx,
  sbfd_stream_if.source  chan
);

  sbfd_pkg::frame_t frame;
  logic             unpack_busy;

  // Hunt for the start byte, collect the frame, check the end byte.
  sbfd_deframer u_deframer (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .unpack_busy (unpack_busy),
    .frame       (frame)
  );

  // Hold the completed frame and advance through its 16 channels.
  sbfd_unpacker u_unpacker (
    .clk   (clk),
    .rst   (rst),
    .frame (frame),
    .busy  (unpack_busy),
    .res   (chan)
  );

endmodule

### rtl/core/sbfd_checker.sv
// Port-level assertions for the SBUS frame deframer and decoder.
`timescale 1ns / 1ps

module sbfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_index,
  input logic        out_last,
  input logic [3:0]  out_flags
);

  // A stalled result holds valid.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // Last marks channel 15 and no other.
  a_last_chan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_index == 4'd15)))
    else $error("last_of_frame does not match channel 15");

  // Within a frame the next channel follows at once with the same flags.
  a_chan_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_index == $past(out_index) + 4'd1) && (out_flags == $past(out_flags)))
    else $error("channel sequence broken inside a frame");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sbus_frame_deframer_decoder_core sbfd_checker u_sbfd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (chan.valid),
  .out_ready (chan.ready),
  .out_index (chan.data.channel_index),
  .out_last  (chan.data.last_of_frame),
  .out_flags ({chan.data.failsafe_active, chan.data.lost_frame,
               chan.data.digital_ch18, chan.data.digital_ch17})
);

### verif/sbus_frame_deframer_decoder_core_tb.sv
`timescale 1ns / 1ps
// Testbench for the SBUS deframer/decoder: directed frames, back-pressure and random byte streams.

module sbus_frame_deframer_decoder_core_tb;

  localparam int WatchdogLimit = 2000;  // cycles with no transfer on either side
  localparam int HoldCycles    = 150;   // long receiver hold-off, fills the unpacker
  localparam int SettleCycles  = 40;    // quiet time after the last channel
  localparam int RandomBytes   = 100;
  localparam int GoodEndPct    = 85;
  localparam int BrokenPct     = 10;

  // One directed frame: a byte sent while hunting, then the start byte, 22
  // data bytes filled in an even/odd pattern, the flag byte and the end byte.
  // Rows marked typed_in carry their expected channel value; the flags come
  // straight from the low nibble of flag_byte.
  typedef struct {
    logic [7:0]  lead;
    logic [7:0]  even_fill;
    logic [7:0]  odd_fill;
    logic [7:0]  flag_byte;
    logic [7:0]  end_byte;
    bit          typed_in;
    logic [10:0] chan_val;
  } frame_row_t;

  frame_row_t directed_rows [10] = '{
    // first frame after reset, everything zero, end mark sent while hunting
    '{8'h00, 8'h00, 8'h00, 8'h00, sbfd_pkg::EndMark, 1'b1, 11'd0},
    // all channels at full scale, all four flags set
    '{8'hFF, 8'hFF, 8'hFF, 8'h0F, sbfd_pkg::EndMark, 1'b1, 11'd2047},
    // upper flag bits are ignored
    '{8'hF0, 8'hFF, 8'hFF, 8'hF5, sbfd_pkg::EndMark, 1'b1, 11'd2047},
    '{8'h0E, 8'h00, 8'h00, 8'h0A, sbfd_pkg::EndMark, 1'b1, 11'd0},
    // start byte inside the frame is plain data
    '{8'h10, sbfd_pkg::StartMark, sbfd_pkg::StartMark, 8'h3C, sbfd_pkg::EndMark, 1'b0, 11'd0},
    '{8'h7F, 8'hAA, 8'h55, 8'h00, sbfd_pkg::EndMark, 1'b0, 11'd0},
    // bad end bytes: nothing comes out
    '{8'h80, 8'h12, 8'h34, 8'h0F, 8'hFF, 1'b1, 11'd0},
    '{8'h01, 8'h56, 8'h78, 8'h03, sbfd_pkg::StartMark, 1'b1, 11'd0},
    // a start mark used up as a bad end byte does not open a frame
    '{8'hE0, 8'h00, 8'hFF, 8'h01, sbfd_pkg::EndMark, 1'b0, 11'd0},
    '{8'hFE, 8'h01, 8'h80, 8'h08, sbfd_pkg::EndMark, 1'b0, 11'd0}
  };

  logic clk;
  logic rst;

  sbfd_stream_if #(.payload_t(sbfd_pkg::rx_item_t)) rx_if ();
  sbfd_stream_if #(.payload_t(sbfd_pkg::result_t))  chan_if ();

  sbus_frame_deframer_decoder_core uut (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_if),
    .chan (chan_if)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Behavioral decoder state: hunting/in-frame flag, position, stored bytes.
  logic              in_frame_q;
  logic [4:0]        frame_pos;
  logic [7:0]        frame_bytes [sbfd_pkg::StoreDepth];
  sbfd_pkg::result_t expected_channels [$];

  // Written by the stimulus with nonblocking assignments so that the monitor
  // still sees the previous row when that row's end byte transfers.
  bit         use_table = 1'b0;
  frame_row_t table_row;

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_seq  = 0;
  int sent_count = 0;
  int err_count  = 0;

  // Queue the 16 channels of a completed frame, from the store or from the table row.
  function automatic void push_channels(bit from_table);
    logic [sbfd_pkg::DataWidth-1:0] packed_data;
    logic [3:0]                     flags;
    sbfd_pkg::result_t              r;
    for (int i = 0; i < sbfd_pkg::DataBytes; i++) begin
      packed_data[8*i +: 8] = frame_bytes[i];
    end
    flags = from_table ? table_row.flag_byte[3:0]
                       : frame_bytes[sbfd_pkg::StoreDepth-1][3:0];
    for (int ch = 0; ch < sbfd_pkg::ChanCount; ch++) begin
      r.channel_index   = 4'(ch);
      r.channel_value   = from_table ? table_row.chan_val
                                     : packed_data[sbfd_pkg::ChanBits*ch +: sbfd_pkg::ChanBits];
      r.digital_ch17    = flags[0];
      r.digital_ch18    = flags[1];
      r.lost_frame      = flags[2];
      r.failsafe_active = flags[3];
      r.last_of_frame   = (r.channel_index == sbfd_pkg::LastChan);
      expected_channels.push_back(r);
    end
  endfunction

  // Advance the decoder by one received byte.
  function automatic void decode_byte(logic [7:0] b);
    if (!in_frame_q) begin
      // drop everything but the start mark while hunting
      if (b == sbfd_pkg::StartMark) begin
        in_frame_q = 1'b1;
        frame_pos  = 5'd1;
      end
    end else if (frame_pos >= 5'd1 && frame_pos <= sbfd_pkg::LastDataPos) begin
      frame_bytes[frame_pos - 5'd1] = b;
      frame_pos = frame_pos + 5'd1;
    end else begin
      // closing byte: back to hunting, emit only on a good end mark
      in_frame_q = 1'b0;
      frame_pos  = 5'd0;
      if (b == sbfd_pkg::EndMark) begin
        push_channels(use_table);
      end
    end
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  task automatic check_channel(input sbfd_pkg::result_t got);
    sbfd_pkg::result_t want;
    if (expected_channels.size() == 0) begin
      $error("channel transfer with nothing pending: index %0d value %0d",
             got.channel_index, got.channel_value);
      err_count++;
    end else begin
      want = expected_channels.pop_front();
      check_field("channel_index", 16'(want.channel_index), 16'(got.channel_index));
      check_field("channel_value", 16'(want.channel_value), 16'(got.channel_value));
      check_field("digital_ch17", 16'(want.digital_ch17), 16'(got.digital_ch17));
      check_field("digital_ch18", 16'(want.digital_ch18), 16'(got.digital_ch18));
      check_field("lost_frame", 16'(want.lost_frame), 16'(got.lost_frame));
      check_field("failsafe_active", 16'(want.failsafe_active), 16'(got.failsafe_active));
      check_field("last_of_frame", 16'(want.last_of_frame), 16'(got.last_of_frame));
    end
  endtask

  // Monitor: both sides are sampled at the edge, so the values seen are the
  // ones that made the transfer. Check outputs before feeding the input byte.
  always @(posedge clk) begin
    if (rst) begin
      in_frame_q = 1'b0;
      frame_pos  = 5'd0;
    end else begin
      if (chan_if.valid && chan_if.ready) begin
        check_channel(chan_if.data);
      end
      if (rx_if.valid && rx_if.ready) begin
        decode_byte(rx_if.data.rx_byte);
      end
    end
  end

  // Receiver: random stalls at the current rate, plus a long hold-off on
  // request. The hold is counted here so the sender keeps running meanwhile.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    chan_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        chan_if.ready <= 1'b0;
        hold_left--;
      end else begin
        chan_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (rst || (rx_if.valid && rx_if.ready) || (chan_if.valid && chan_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("sbus_frame_deframer_decoder_core_tb: done, errors");
    $finish;
  end

  // Offer one byte, idling first at the current rate; return after its transfer.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid        <= 1'b1;
    rx_if.data.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) begin
      @(posedge clk);
    end
    sent_count++;
  endtask

  // Start mark, 22 data bytes and the flag byte (body), then the end byte.
  task automatic send_frame(input logic [7:0] body [sbfd_pkg::StoreDepth],
                            input logic [7:0] end_byte);
    send_byte(sbfd_pkg::StartMark);
    foreach (body[i]) begin
      send_byte(body[i]);
    end
    send_byte(end_byte);
  endtask

  // Random frame with random content. Most are well formed with a little noise
  // ahead; some end badly and a few are cut short so the next start mark lands
  // inside the frame as data.
  task automatic send_random_frame();
    logic [7:0] body [sbfd_pkg::StoreDepth];
    logic [7:0] noise;
    int         cut;
    repeat ($urandom_range(2)) begin
      noise = 8'($urandom_range(255));
      send_byte(noise == sbfd_pkg::StartMark ? 8'hF0 : noise);
    end
    foreach (body[i]) begin
      body[i] = 8'($urandom_range(255));
    end
    if ($urandom_range(99) < BrokenPct) begin
      cut = $urandom_range(1, sbfd_pkg::StoreDepth);
      send_byte(sbfd_pkg::StartMark);
      for (int i = 0; i < cut; i++) begin
        send_byte(body[i]);
      end
    end else if ($urandom_range(99) < GoodEndPct) begin
      send_frame(body, sbfd_pkg::EndMark);
    end else begin
      send_frame(body, 8'($urandom_range(1, 255)));
    end
  endtask

  initial begin : stimulus
    logic [7:0] body [sbfd_pkg::StoreDepth];
    int         rand_base;
    int         phase;
    rst                <= 1'b1;
    rx_if.valid        <= 1'b0;
    rx_if.data.rx_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed frames, no idling on either side.
    foreach (directed_rows[r]) begin
      use_table <= directed_rows[r].typed_in;
      table_row <= directed_rows[r];
      for (int i = 0; i < sbfd_pkg::DataBytes; i++) begin
        body[i] = i[0] ? directed_rows[r].odd_fill : directed_rows[r].even_fill;
      end
      body[sbfd_pkg::StoreDepth-1] = directed_rows[r].flag_byte;
      send_byte(directed_rows[r].lead);
      send_frame(body, directed_rows[r].end_byte);
    end
    use_table <= 1'b0;

    // Hold the receiver off while frames keep coming back to back: the second
    // closing byte must wait until the unpacker drains.
    hold_seq <= hold_seq + 1;
    repeat (2) begin
      foreach (body[i]) begin
        body[i] = 8'($urandom_range(255));
      end
      send_frame(body, sbfd_pkg::EndMark);
    end

    // Random part in four idling phases: none, sender idle, receiver
    // stalling, both.
    rand_base = sent_count;
    while (sent_count - rand_base < RandomBytes) begin
      phase = (sent_count - rand_base) * 4 / RandomBytes;
      case (phase)
        0: begin
          idle_pct  <= 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct  <= 68;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  <= 0;
          stall_pct <= 68;
        end
        default: begin
          idle_pct  <= 23;
          stall_pct <= 23;
        end
      endcase
      send_random_frame();
    end
    rx_if.valid <= 1'b0;

    // Drain, then give a stray channel time to show up.
    while (expected_channels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("sbus_frame_deframer_decoder_core_tb: done, clean");
    end else begin
      $display("sbus_frame_deframer_decoder_core_tb: done, errors");
    end
    $finish;
  end

endmodule
